// ===== sv/emwe_pkg.sv =====
// emwe_pkg: shared widths, coefficient and normalization tables, side-band type
package emwe_pkg;

	localparam int X_W         = 25;
	localparam int SCALE_W     = 5;
	localparam int SHIFT_W     = 16;
	localparam int POLY_W      = 3;
	localparam int ORDER_W     = 3;
	localparam int VALUE_W     = 32;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_TUSER_W = 1;

	localparam int X_FRAC_BITS = 24;
	localparam int MAX_SCALE   = 16;
	localparam int MAX_ORDER   = 4;
	localparam int WORK_FRAC   = 24;
	localparam int K_FRAC      = 28;
	localparam int OUT_FRAC    = 16;
	localparam int SH_BASE     = WORK_FRAC + K_FRAC - OUT_FRAC;

	localparam int U_W     = 42;
	localparam int A_W     = 25;
	localparam int ACC_W   = 39;
	localparam int MAG_W   = 38;
	localparam int SPLIT   = 19;
	localparam int COEF_W  = 15;
	localparam int NORM_W  = 30;
	localparam int PP_W    = SPLIT + NORM_W;
	localparam int FULL_W  = 68;
	localparam int SHIFT_SEL_W = 6;
	localparam int HALF_W  = 4;

	localparam int ENTRIES   = 15;
	localparam int NUM_COEF  = 5;
	localparam int NUM_STEPS = 4;
	localparam int IDX_W     = 4;

	localparam int ONE_FIX   = 1 << X_FRAC_BITS;
	localparam int HALF_WORK = 1 << (WORK_FRAC - 1);

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic [NORM_W-1:0] norm_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic [NUM_STEPS-1:0][COEF_W-1:0] coefs;
		norm_t                            norm;
		logic [A_W-1:0]                   a;
		logic                             flip;
		logic [HALF_W-1:0]                s_half;
		logic                             zero;
		logic                             support;
	} side_t;

	localparam coef_t POLY_COEF [ENTRIES][NUM_COEF] = '{
		'{1, 0, 0, 0, 0},
		'{-1, 2, 0, 0, 0}, '{-2, 3, 0, 0, 0},
		'{1, -24, 30, 0, 0}, '{3, -16, 15, 0, 0}, '{4, -15, 12, 0, 0},
		'{1, 4, -30, 28, 0}, '{-4, 105, -300, 210, 0},
		'{-5, 48, -105, 64, 0}, '{-16, 105, -192, 105, 0},
		'{1, 30, 210, -840, 630}, '{-5, -144, 1155, -2240, 1260},
		'{22, -735, 3504, -5460, 2700}, '{35, -512, 1890, -2560, 1155},
		'{32, -315, 960, -1155, 480}
	};

	// column 0 for even scale, column 1 carries the extra sqrt(2) for odd scale
	localparam norm_t NORM_Q28 [ENTRIES][2] = '{
		'{268435456, 379625062},
		'{464943848, 657529896}, '{268435456, 379625062},
		'{89478485, 126541687}, '{232471924, 328764948}, '{200079976, 282955815},
		'{252151205, 356595653}, '{58577419, 82840980},
		'{192583664, 272354429}, '{65491545, 92619032},
		'{27835460, 39365285}, '{30791659, 43545981},
		'{18527588, 26201966}, '{35276277, 49888187},
		'{39952629, 56501551}
	};

	function automatic logic [IDX_W-1:0] entry_index(logic [ORDER_W-1:0] order,
			logic [POLY_W-1:0] poly);
		logic [IDX_W-1:0] base;
		unique case (order)
			3'd1: base = 4'd1;
			3'd2: base = 4'd3;
			3'd3: base = 4'd6;
			3'd4: base = 4'd10;
			default: base = 4'd0;
		endcase
		return base + IDX_W'(poly);
	endfunction

endpackage

// ===== sv/emwe_horner_step.sv =====
// emwe_horner_step: one Horner step, multiply stage then round-and-add stage
module emwe_horner_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  emwe_pkg::acc_t  acc_in,
	input  emwe_pkg::side_t side_in,
	output logic            out_valid,
	input  logic            out_ready,
	output emwe_pkg::acc_t  acc_out,
	output emwe_pkg::side_t side_out
);
	import emwe_pkg::*;

	localparam int PROD_W = ACC_W + A_W + 1;

	logic                     v_s1, v_s2;
	logic                     en_s1, en_s2;
	logic signed [PROD_W-1:0] prod_d, prod_s1;
	logic signed [PROD_W-1:0] bias, rsum, rnd;
	acc_t                     sum, acc_s2;
	side_t                    side_s1, side_s2, side_nx;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	assign prod_d = acc_in * $signed({1'b0, side_in.a});

	// round half away from zero
	always_comb begin
		bias    = prod_s1[PROD_W-1] ? PROD_W'(HALF_WORK - 1) : PROD_W'(HALF_WORK);
		rsum    = prod_s1 + bias;
		rnd     = rsum >>> WORK_FRAC;
		sum     = ACC_W'(rnd) + (ACC_W'($signed(side_s1.coefs[NUM_STEPS-1])) <<< WORK_FRAC);
		side_nx = side_s1;
		side_nx.coefs = {side_s1.coefs[NUM_STEPS-2:0], {COEF_W{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			prod_s1 <= prod_d;
			side_s1 <= side_in;
		end
		if (en_s2 && v_s1) begin
			acc_s2  <= sum;
			side_s2 <= side_nx;
		end
	end

	assign out_valid = v_s2;
	assign acc_out   = acc_s2;
	assign side_out  = side_s2;

endmodule

// ===== sv/exact_multiwavelet_eval.sv =====
// exact_multiwavelet_eval: pipelined closed-form multiwavelet evaluator
//
//  channel  dir  handshake              contents
//  s_axis   in   tvalid/tready          tdata: x_value, scale_index, shift_index, poly_index
//  m_axis   out  tvalid/tready          tdata: wavelet_value; tuser: in_support
//  cfg      in   cfg_valid/cfg_ready    cfg_data: basis_order
//
//  one item per cycle while the output is not stalled; 13 register stages
//  pipeline depth set by the four two-stage Horner multiply units and the split norm multiply
//  arst_n clears all stage valid bits and basis_order to zero
//  each stage holds while its successor is full and stalled, so bubbles are squeezed out
//  cfg_ready is always high
module exact_multiwavelet_eval (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// x_value[24:0], scale_index[29:25], shift_index[45:30], poly_index[48:46], zero fill
	input  logic [emwe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// wavelet_value[31:0]
	output logic [emwe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// in_support[0]
	output logic [emwe_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [emwe_pkg::ORDER_W-1:0]     cfg_data
);
	import emwe_pkg::*;

	logic [ORDER_W-1:0]      basis_q;

	logic [X_W-1:0]          x_in;
	logic [SCALE_W-1:0]      scale_in, scale_sat;
	logic [SHIFT_W-1:0]      shift_in;
	logic [POLY_W-1:0]       poly_in;
	logic signed [U_W-1:0]   u_d;

	logic                    v_s1, v_s2, v_s11, v_s12, v_s13;
	logic                    en_s1, en_s2, en_s11, en_s12, en_s13;

	logic signed [U_W-1:0]   u_s1;
	logic [SCALE_W-1:0]      scale_s1;
	logic [POLY_W-1:0]       poly_s1;

	logic                    support, tneg, order_ok;
	logic [A_W:0]            two_u;
	logic [IDX_W-1:0]        idx;
	side_t                   side_d, side_s2;
	acc_t                    acc_d, acc_s2;

	logic                    h_valid [NUM_STEPS+1];
	logic                    h_ready [NUM_STEPS+1];
	acc_t                    h_acc   [NUM_STEPS+1];
	side_t                   h_side  [NUM_STEPS+1];

	acc_t                    acc_abs;
	logic [MAG_W-1:0]        mag;
	logic [PP_W-1:0]         pp_hi_s11, pp_lo_s11;
	logic                    neg_s11, kill_s11, support_s11;
	logic [HALF_W-1:0]       half_s11, half_s12;
	logic [FULL_W-1:0]       prod_s12;
	logic                    neg_s12, kill_s12, support_s12;

	logic [SHIFT_SEL_W-1:0]  sh;
	logic [FULL_W-1:0]       rnd, shifted;
	logic [VALUE_W-1:0]      value_d, value_s13;
	logic                    support_s13;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basis_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			basis_q <= cfg_data;
		end
	end

	// stall chain
	assign en_s13        = !v_s13 || m_axis_tready;
	assign en_s12        = !v_s12 || en_s13;
	assign en_s11        = !v_s11 || en_s12;
	assign h_ready[NUM_STEPS] = en_s11;
	assign en_s2         = !v_s2 || h_ready[0];
	assign en_s1         = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;

	// stage 1: scaled coordinate
	always_comb begin
		x_in      = s_axis_tdata[X_W-1:0];
		scale_in  = s_axis_tdata[X_W +: SCALE_W];
		shift_in  = s_axis_tdata[X_W+SCALE_W +: SHIFT_W];
		poly_in   = s_axis_tdata[X_W+SCALE_W+SHIFT_W +: POLY_W];
		scale_sat = (scale_in > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : scale_in;
		u_d       = $signed(U_W'(x_in) << scale_sat) - $signed(U_W'(shift_in) << X_FRAC_BITS);
	end

	// stage 2: support, |t|, table select
	always_comb begin
		support  = !u_s1[U_W-1] && (u_s1 <= $signed(U_W'(ONE_FIX)));
		two_u    = {u_s1[A_W-1:0], 1'b0};
		tneg     = two_u < (A_W+1)'(ONE_FIX);
		order_ok = (basis_q <= ORDER_W'(MAX_ORDER)) && (poly_s1 <= basis_q);
		idx      = order_ok ? entry_index(basis_q, poly_s1) : '0;
		side_d.a = tneg ? A_W'((A_W+1)'(ONE_FIX) - two_u) : A_W'(two_u - (A_W+1)'(ONE_FIX));
		side_d.coefs[3] = POLY_COEF[idx][3];
		side_d.coefs[2] = POLY_COEF[idx][2];
		side_d.coefs[1] = POLY_COEF[idx][1];
		side_d.coefs[0] = POLY_COEF[idx][0];
		side_d.norm     = NORM_Q28[idx][scale_s1[0]];
		side_d.flip     = tneg && (basis_q[0] == poly_s1[0]);
		side_d.s_half   = scale_s1[SCALE_W-1:1];
		side_d.zero     = !order_ok;
		side_d.support  = support;
		acc_d           = ACC_W'(POLY_COEF[idx][NUM_COEF-1]) <<< WORK_FRAC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else begin
			if (en_s1)  v_s1  <= s_axis_tvalid;
			if (en_s2)  v_s2  <= v_s1;
			if (en_s11) v_s11 <= h_valid[NUM_STEPS];
			if (en_s12) v_s12 <= v_s11;
			if (en_s13) v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_axis_tvalid) begin
			u_s1     <= u_d;
			scale_s1 <= scale_sat;
			poly_s1  <= poly_in;
		end
		if (en_s2 && v_s1) begin
			acc_s2  <= acc_d;
			side_s2 <= side_d;
		end
	end

	// Horner steps
	assign h_valid[0] = v_s2;
	assign h_acc[0]   = acc_s2;
	assign h_side[0]  = side_s2;

	for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
		emwe_horner_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (h_valid[i]),
			.in_ready  (h_ready[i]),
			.acc_in    (h_acc[i]),
			.side_in   (h_side[i]),
			.out_valid (h_valid[i+1]),
			.out_ready (h_ready[i+1]),
			.acc_out   (h_acc[i+1]),
			.side_out  (h_side[i+1])
		);
	end

	// stage 11: magnitude and partial products with the normalization
	always_comb begin
		acc_abs = h_acc[NUM_STEPS][ACC_W-1] ? -h_acc[NUM_STEPS] : h_acc[NUM_STEPS];
		mag     = acc_abs[MAG_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en_s11 && h_valid[NUM_STEPS]) begin
			pp_hi_s11   <= PP_W'(mag[MAG_W-1:SPLIT]) * PP_W'(h_side[NUM_STEPS].norm);
			pp_lo_s11   <= PP_W'(mag[SPLIT-1:0]) * PP_W'(h_side[NUM_STEPS].norm);
			neg_s11     <= h_acc[NUM_STEPS][ACC_W-1] ^ h_side[NUM_STEPS].flip;
			kill_s11    <= h_side[NUM_STEPS].zero || !h_side[NUM_STEPS].support;
			support_s11 <= h_side[NUM_STEPS].support;
			half_s11    <= h_side[NUM_STEPS].s_half;
		end
		if (en_s12 && v_s11) begin
			prod_s12    <= (FULL_W'(pp_hi_s11) << SPLIT) + FULL_W'(pp_lo_s11);
			neg_s12     <= neg_s11;
			kill_s12    <= kill_s11;
			support_s12 <= support_s11;
			half_s12    <= half_s11;
		end
		if (en_s13 && v_s12) begin
			value_s13   <= value_d;
			support_s13 <= support_s12;
		end
	end

	// stage 13: scale shift, rounding, saturation, zeroing when killed
	always_comb begin
		sh      = SHIFT_SEL_W'(SH_BASE) - SHIFT_SEL_W'(half_s12);
		rnd     = prod_s12 + (FULL_W'(1) << (sh - SHIFT_SEL_W'(1)));
		shifted = rnd >> sh;
		if (kill_s12) begin
			value_d = '0;
		end else if (neg_s12) begin
			if (shifted > FULL_W'(32'h8000_0000)) begin
				value_d = 32'h8000_0000;
			end else begin
				value_d = -shifted[VALUE_W-1:0];
			end
		end else begin
			if (shifted > FULL_W'(32'h7FFF_FFFF)) begin
				value_d = 32'h7FFF_FFFF;
			end else begin
				value_d = shifted[VALUE_W-1:0];
			end
		end
	end

	assign m_axis_tvalid = v_s13;
	assign m_axis_tdata  = value_s13;
	assign m_axis_tuser  = support_s13;

endmodule

// ===== sv/emwe_checker.sv =====
// emwe_checker: port-level checks for exact_multiwavelet_eval and its bind
module emwe_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [emwe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [emwe_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
	import emwe_pkg::*;

	// a stalled output transfer keeps its valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped while stalled");

	// a stalled output transfer keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output payload changed while stalled");

	// outside the support the value is zero
	a_zero_outside: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("nonzero value outside support");

	// an empty or draining output never blocks the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid || m_axis_tready |-> s_axis_tready)
		else $error("input stalled with output free");

endmodule

bind exact_multiwavelet_eval emwe_checker u_emwe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
